// ===== rtl/core/overlapping_partition_assign_defines.svh =====
// assertion macros shared by the checker
`ifndef OVERLAPPING_PARTITION_ASSIGN_DEFINES_SVH
`define OVERLAPPING_PARTITION_ASSIGN_DEFINES_SVH

`define OPA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: lbl failed");

`define OPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: lbl failed");

`endif

// ===== rtl/core/opa_pkg.sv =====
package opa_pkg;

  localparam int unsigned MaxPartitions = 16;
  localparam int unsigned MaxDim        = 128;
  localparam int unsigned ResultCap     = 16;
  localparam int unsigned PartW         = $clog2(MaxPartitions);
  localparam int unsigned DimW          = $clog2(MaxDim);
  localparam int unsigned AddrW         = PartW + DimW;
  localparam int unsigned CntW          = PartW + 1;
  localparam int unsigned AccW          = 48;

  localparam logic [2:0] RegMode  = 3'd0;
  localparam logic [2:0] RegParts = 3'd1;
  localparam logic [2:0] RegDim   = 3'd2;
  localparam logic [2:0] RegRatio = 3'd3;
  localparam logic [2:0] RegProbe = 3'd4;

  localparam logic KindLoad   = 1'b0;
  localparam logic KindVector = 1'b1;

  typedef struct packed {
    logic           clear;
    logic           acc_en;
    logic [PartW-1:0] part;
    logic           rank_init;
    logic           rank_step;
    logic [PartW-1:0] pos;
  } opa_cmd_t;

  typedef struct packed {
    logic           swap;
    logic           pass;
  } opa_sts_t;

endpackage

// ===== rtl/core/opa_datapath.sv =====
module opa_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  opa_pkg::opa_cmd_t             cmd_i,
  output opa_pkg::opa_sts_t             sts_o,
  input  logic                          st_we_i,
  input  logic [opa_pkg::AddrW-1:0]     st_waddr_i,
  input  logic [15:0]                   st_wdata_i,
  input  logic [opa_pkg::AddrW-1:0]     st_raddr_i,
  input  logic signed [15:0]            value_i,
  input  logic [15:0]                   ratio_i,
  output logic [opa_pkg::PartW-1:0]     rank_pid_o,
  output logic [opa_pkg::AccW-1:0]      rank_dist_o
);
  localparam int unsigned P = opa_pkg::MaxPartitions;
  localparam int unsigned W = opa_pkg::AccW;

  logic [15:0] store_q [opa_pkg::MaxPartitions*opa_pkg::MaxDim];
  logic [15:0] rd_q;
  logic [W-1:0] acc_q [P];
  logic [opa_pkg::PartW-1:0] order_q [P];
  logic signed [16:0] diff;
  logic [16:0] mag;
  logic [33:0] sq_q;
  logic acc_en_q;
  logic [opa_pkg::PartW-1:0] part_q;
  logic [W:0] sum;
  logic [W-1:0] d0, di, dprev, dcur;
  logic [W+7:0] lhs, rhs;

  always_ff @(posedge clk_i) begin
    if (st_we_i) store_q[st_waddr_i] <= st_wdata_i;
    rd_q <= store_q[st_raddr_i];
  end

  assign diff = {value_i[15], value_i} - {rd_q[15], rd_q};
  assign mag  = diff[16] ? 17'(-diff) : 17'(diff);

  always_ff @(posedge clk_i) begin
    sq_q <= 34'(mag * mag);
  end

  assign sum = {1'b0, acc_q[part_q]} + (W+1)'(sq_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < P; i++) acc_q[i] <= '0;
      for (int i = 0; i < P; i++) order_q[i] <= '0;
      acc_en_q <= 1'b0;
      part_q   <= '0;
    end else begin
      acc_en_q <= cmd_i.acc_en;
      part_q   <= cmd_i.part;
      if (cmd_i.clear) begin
        for (int i = 0; i < P; i++) acc_q[i] <= '0;
      end else if (acc_en_q) begin
        acc_q[part_q] <= sum[W] ? {W{1'b1}} : sum[W-1:0];
      end
      if (cmd_i.rank_init) begin
        for (int i = 0; i < P; i++) order_q[i] <= opa_pkg::PartW'(i);
      end else if (cmd_i.rank_step && sts_o.swap) begin
        order_q[cmd_i.pos]                          <= order_q[cmd_i.pos - 1'b1];
        order_q[cmd_i.pos - 1'b1]                   <= order_q[cmd_i.pos];
      end
    end
  end

  // adjacent compare for the bubble pass
  assign dprev = acc_q[order_q[cmd_i.pos - 1'b1]];
  assign dcur  = acc_q[order_q[cmd_i.pos]];
  assign sts_o.swap = (cmd_i.pos != '0) && (dprev > dcur);

  assign d0  = acc_q[order_q[0]];
  assign di  = acc_q[order_q[cmd_i.pos]];
  assign lhs = {di - d0, 8'd0};
  assign rhs = (W+8)'(d0 * ratio_i);
  assign sts_o.pass = (d0 == '0) ? (di == '0 && ratio_i != '0) : (lhs < rhs);

  assign rank_pid_o  = order_q[cmd_i.pos];
  assign rank_dist_o = di;
endmodule

// ===== rtl/core/opa_ctrl.sv =====
module opa_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic                        in_kind_i,
  input  logic                        in_last_i,
  input  logic [opa_pkg::DimW-1:0]    in_elem_i,
  input  logic [31:0]                 in_vid_i,
  input  logic                        mode_i,
  input  logic [4:0]                  parts_i,
  input  logic [7:0]                  dim_i,
  input  logic [4:0]                  probe_i,
  output opa_pkg::opa_cmd_t           cmd_o,
  input  opa_pkg::opa_sts_t           sts_i,
  output logic [opa_pkg::AddrW-1:0]   raddr_o,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic                        out_last_o,
  output logic [31:0]                 out_vid_o,
  output logic [opa_pkg::PartW-1:0]   out_pid_o,
  output logic [opa_pkg::AccW-1:0]    out_dist_o,
  input  logic [opa_pkg::PartW-1:0]   rank_pid_i,
  input  logic [opa_pkg::AccW-1:0]    rank_dist_i
);
  localparam int unsigned PW = opa_pkg::PartW;
  localparam int unsigned CW = opa_pkg::CntW;

  typedef enum logic [2:0] {
    StIdle, StRead, StAcc, StDrain, StSort, StCount, StEmit, StClear
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] part_q, part_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [CW-1:0] pass_q, pass_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] emit_q, emit_d;
  logic [opa_pkg::DimW-1:0] elem_q, elem_d;
  logic last_q, last_d;
  logic [31:0] vid_q, vid_d;
  logic [2:0] drain_q, drain_d;
  logic [CW-1:0] np, probe_n;
  logic [8:0] dim_n;
  logic in_range;

  assign np      = (parts_i == 5'd0) ? CW'(1) :
                   (parts_i > 5'(opa_pkg::MaxPartitions)) ? CW'(opa_pkg::MaxPartitions) :
                   CW'(parts_i);
  assign probe_n = (probe_i == 5'd0) ? CW'(1) : (CW'(probe_i) > np) ? np : CW'(probe_i);
  assign dim_n   = (dim_i == 8'd0) ? 9'd1 : {1'b0, dim_i};
  assign in_range = {2'b0, in_elem_i} < dim_n;

  assign s_axis_tready = (state_q == StIdle);
  assign raddr_o = {part_q[PW-1:0], elem_q};

  always_comb begin
    state_d = state_q; part_d = part_q; pos_d = pos_q; pass_d = pass_q;
    cnt_d = cnt_q; emit_d = emit_q; elem_d = elem_q; last_d = last_q;
    vid_d = vid_q; drain_d = drain_q;
    cmd_o = '0;
    cmd_o.part = part_q[PW-1:0];
    cmd_o.pos  = pos_q;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid && in_kind_i == opa_pkg::KindVector) begin
          elem_d = in_elem_i; last_d = in_last_i; vid_d = in_vid_i;
          part_d = '0;
          state_d = in_range ? StRead : (in_last_i ? StDrain : StIdle);
          drain_d = '0;
        end
      end
      StRead: state_d = StAcc;
      StAcc: begin
        cmd_o.acc_en = 1'b1;
        if (part_q + 1'b1 == np) begin
          state_d = StDrain; drain_d = '0;
        end else begin
          part_d = part_q + 1'b1; state_d = StRead;
        end
      end
      StDrain: begin
        drain_d = drain_q + 3'd1;
        if (drain_q == 3'd2) begin
          if (last_q) begin
            state_d = StSort; cmd_o.rank_init = 1'b1;
            pos_d = PW'(1); pass_d = '0;
          end else state_d = StIdle;
        end
      end
      StSort: begin
        cmd_o.rank_step = (np != CW'(1));
        if (np == CW'(1) || CW'(pos_q) + 1'b1 >= np) begin
          pos_d = PW'(1);
          if (pass_q + 1'b1 >= np) begin
            state_d = StCount; pos_d = PW'(1); cnt_d = CW'(1);
          end else pass_d = pass_q + 1'b1;
        end else pos_d = pos_q + 1'b1;
      end
      StCount: begin
        if (mode_i) begin
          cnt_d = probe_n; state_d = StEmit; emit_d = '0; pos_d = '0;
        end else if (cnt_q < np && sts_i.pass && !(CW'(pos_q) == 0 && cnt_q != CW'(1))) begin
          cnt_d = cnt_q + 1'b1; pos_d = pos_q + 1'b1;
          if (pos_q == PW'(opa_pkg::MaxPartitions - 1)) begin
            state_d = StEmit; emit_d = '0; pos_d = '0;
          end
        end else begin
          state_d = StEmit; emit_d = '0; pos_d = '0;
        end
      end
      StEmit: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          if (emit_q == cnt_q) begin
            if (!m_axis_tvalid || m_axis_tready) state_d = StClear;
          end else begin
            emit_d = emit_q + 1'b1; pos_d = pos_q + 1'b1;
          end
        end
      end
      StClear: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          cmd_o.clear = 1'b1; state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  logic load_out;
  assign load_out = (state_q == StEmit) && (emit_q != cnt_q) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; part_q <= '0; pos_q <= '0; pass_q <= '0; cnt_q <= '0;
      emit_q <= '0; elem_q <= '0; last_q <= 1'b0; vid_q <= '0;
      drain_q <= '0; m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d; part_q <= part_d; pos_q <= pos_d; pass_q <= pass_d;
      cnt_q <= cnt_d; emit_q <= emit_d; elem_q <= elem_d; last_q <= last_d;
      vid_q <= vid_d; drain_q <= drain_d;
      if (load_out) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_vid_o  <= vid_q;
      out_pid_o  <= rank_pid_i;
      out_dist_o <= rank_dist_i;
      out_last_o <= (emit_q + 1'b1 == cnt_q);
    end
  end
endmodule

// ===== rtl/core/overlapping_partition_assign.sv =====
// Assigns a vector to its nearest IVF partitions. Load beats (tuser=0) write one
// Q8.8 centroid element. A vector beat (tuser=1) reads each of the partitions_in_use
// centroids through a single registered store port and one shared squarer. On the
// beat with tlast the partitions are ranked by a bubble sort, then the results are
// counted (by the ratio test, or set to the probe count in mode 1) and one result
// beat per chosen partition is emitted, last result flagged by tlast. Accumulators
// are cleared after the final result. Configure only while idle.
module overlapping_partition_assign (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // centroid_index[3:0], element_index[10:4], value[26:11], vector_id[58:27], zero fill
  input  logic [63:0] s_axis_tdata,
  // kind
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // vector_id_out[31:0], partition_id[35:32], distance[83:36], zero fill
  output logic [87:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  logic mode_q; logic [4:0] parts_q; logic [7:0] dim_q;
  logic [15:0] ratio_q; logic [4:0] probe_q;
  logic [15:0] value_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0; parts_q <= 5'd16; dim_q <= 8'd128; ratio_q <= 16'd26; probe_q <= 5'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        opa_pkg::RegMode:  mode_q  <= cfg_data_i[0];
        opa_pkg::RegParts: parts_q <= cfg_data_i[4:0];
        opa_pkg::RegDim:   dim_q   <= cfg_data_i[7:0];
        opa_pkg::RegRatio: ratio_q <= cfg_data_i;
        opa_pkg::RegProbe: probe_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // element value held for the whole accumulate pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else if (s_axis_tvalid && s_axis_tready && (s_axis_tuser == opa_pkg::KindVector)) begin
      value_q <= s_axis_tdata[26:11];
    end
  end

  opa_pkg::opa_cmd_t cmd;
  opa_pkg::opa_sts_t sts;
  logic [opa_pkg::AddrW-1:0] raddr;
  logic [opa_pkg::PartW-1:0] rank_pid;
  logic [opa_pkg::AccW-1:0] rank_dist;
  logic st_we;
  logic [3:0] out_pid;
  logic [47:0] out_dist;
  logic [31:0] out_vid;

  assign st_we = s_axis_tvalid && s_axis_tready && (s_axis_tuser == opa_pkg::KindLoad);

  opa_ctrl u_ctrl (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
    .in_kind_i(s_axis_tuser), .in_last_i(s_axis_tlast),
    .in_elem_i(s_axis_tdata[10:4]), .in_vid_i(s_axis_tdata[58:27]),
    .mode_i(mode_q), .parts_i(parts_q), .dim_i(dim_q), .probe_i(probe_q),
    .cmd_o(cmd), .sts_i(sts), .raddr_o(raddr),
    .m_axis_tvalid, .m_axis_tready, .out_last_o(m_axis_tlast),
    .out_vid_o(out_vid), .out_pid_o(out_pid), .out_dist_o(out_dist),
    .rank_pid_i(rank_pid), .rank_dist_i(rank_dist)
  );

  opa_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .st_we_i(st_we),
    .st_waddr_i({s_axis_tdata[3:0], s_axis_tdata[10:4]}), .st_wdata_i(s_axis_tdata[26:11]),
    .st_raddr_i(raddr), .value_i(value_q), .ratio_i(ratio_q),
    .rank_pid_o(rank_pid), .rank_dist_o(rank_dist)
  );

  assign m_axis_tdata = {4'd0, out_dist, out_pid, out_vid};
endmodule

// ===== rtl/core/opa_checker.sv =====
`include "overlapping_partition_assign_defines.svh"
module opa_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic m_axis_tlast
);
  `OPA_ASSERT_IMPL(a_no_in_while_out, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  `OPA_ASSERT_NEXT(a_out_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `OPA_ASSERT_NEXT(a_last_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tlast))
endmodule

bind overlapping_partition_assign opa_checker u_opa_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tlast
);
